[hw/rtl/rsam_pkg.sv]
package rsam_pkg;

  localparam int ELEMENTS_DEF = 1024;
  localparam int CFG_W = 11;

  localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_MIN    = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_ADD    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic signed [63:0] min_v;
    logic signed [63:0] add_v;
    logic signed [63:0] asg_v;
    logic               asg_valid;
  } node_t;

  typedef enum logic [2:0] {
    WS_CLEAR,
    WS_APPLY_OP,
    WS_APPLY_TAG,
    WS_STRIP,
    WS_COMBINE
  } wsel_t;

  typedef struct packed {
    logic  rd;
    logic  wr;
    wsel_t wsel;
    logic  op_load;
    logic  tag_load;
    logic  left_load;
    logic  acc_init;
    logic  acc_fold;
    logic  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic tag_active;
    logic out_full;
  } dp_status_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? VAL_MIN : VAL_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] min64(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic node_t node_clear();
    node_t n;
    n.min_v     = VAL_MAX;
    n.add_v     = '0;
    n.asg_v     = '0;
    n.asg_valid = 1'b0;
    return n;
  endfunction

  function automatic node_t node_assign(input logic signed [63:0] v);
    node_t n;
    n.min_v     = v;
    n.add_v     = '0;
    n.asg_v     = v;
    n.asg_valid = 1'b1;
    return n;
  endfunction

  function automatic node_t node_add(input node_t n, input logic signed [63:0] a);
    node_t r;
    r = n;
    if (n.asg_valid) begin
      r.asg_v = sat_add(n.asg_v, a);
      r.min_v = r.asg_v;
    end else begin
      r.add_v = sat_add(n.add_v, a);
      r.min_v = sat_add(n.min_v, a);
    end
    return r;
  endfunction

endpackage

[hw/rtl/rsam_in_if.sv]
interface rsam_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [9:0]         range_low;
  logic [10:0]        range_high;
  logic signed [63:0] operand_value;

  modport source (output valid, opcode, range_low, range_high, operand_value,
                  input ready);
  modport sink (input valid, opcode, range_low, range_high, operand_value,
                output ready);
endinterface

[hw/rtl/rsam_out_if.sv]
interface rsam_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] min_value;

  modport source (output valid, min_value, input ready);
  modport sink (input valid, min_value, output ready);
endinterface

[hw/rtl/rsam_dp.sv]
module rsam_dp #(
  parameter int ELEMENTS = rsam_pkg::ELEMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rsam_pkg::dp_cmd_t               cmd,
  input  logic [$clog2(4*ELEMENTS)-1:0]   addr,
  input  logic [1:0]                      in_opcode,
  input  logic signed [63:0]              in_value,
  output rsam_pkg::dp_status_t            status,
  output logic signed [63:0]              out_value,
  output logic                            out_valid,
  input  logic                            out_ready
);
  import rsam_pkg::*;

  localparam int NODES = 4 * ELEMENTS;

  node_t              mem [NODES];
  node_t              rdata;
  node_t              tag;
  node_t              wdata;
  logic signed [63:0] opval;
  logic               op_assign;
  logic signed [63:0] left;
  logic signed [63:0] acc;

  always_comb begin
    node_t s;
    s = node_clear();
    s.min_v = rdata.min_v;
    unique case (cmd.wsel)
      WS_CLEAR:     wdata = node_clear();
      WS_APPLY_OP:  wdata = op_assign ? node_assign(opval) : node_add(rdata, opval);
      WS_APPLY_TAG: wdata = tag.asg_valid ? node_assign(tag.asg_v) : node_add(rdata, tag.add_v);
      WS_STRIP:     wdata = s;
      WS_COMBINE: begin
        wdata = s;
        wdata.min_v = min64(left, rdata.min_v);
      end
      default:      wdata = node_clear();
    endcase
  end

  assign status.tag_active = rdata.asg_valid || (rdata.add_v != '0);
  assign status.out_full   = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      opval     <= in_value;
      op_assign <= (in_opcode == OP_ASSIGN);
    end
    if (cmd.tag_load) begin
      tag <= rdata;
    end
    if (cmd.left_load) begin
      left <= rdata.min_v;
    end
    if (cmd.acc_init) begin
      acc <= VAL_MAX;
    end else if (cmd.acc_fold) begin
      acc <= min64(acc, rdata.min_v);
    end
    if (cmd.out_load) begin
      out_value <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid)
    else $error("result loaded over a beat not yet taken");

endmodule

[hw/rtl/rsam_ctrl.sv]
module rsam_ctrl #(
  parameter int ELEMENTS = rsam_pkg::ELEMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rsam_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                            in_valid,
  input  logic [1:0]                      in_opcode,
  input  logic [9:0]                      in_low,
  input  logic [10:0]                     in_high,
  output logic                            in_ready,
  output rsam_pkg::dp_cmd_t               cmd,
  output logic [$clog2(4*ELEMENTS)-1:0]   addr,
  input  rsam_pkg::dp_status_t            status
);
  import rsam_pkg::*;

  localparam int NODES = 4 * ELEMENTS;
  localparam int NW    = $clog2(NODES);
  localparam int IW    = $clog2(ELEMENTS + 1);
  localparam int XW    = (IW > CFG_W) ? IW : CFG_W;
  localparam int SD    = $clog2(ELEMENTS) + 1;
  localparam int SPW   = $clog2(SD + 1);
  localparam int SIW   = $clog2(SD);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_VISIT, S_COV, S_PUSH_K,
    S_CH_RD_L, S_CH_WR_L, S_CH_RD_R, S_CH_WR_R, S_DESCEND,
    S_RETURN, S_CMB_L, S_CMB_R, S_CMB_W, S_DONE
  } state_t;

  state_t          state;
  logic [IW-1:0]   count;
  opcode_t         op;
  logic [IW-1:0]   ql;
  logic [IW-1:0]   qr;
  logic [NW-1:0]   cur_k;
  logic [IW-1:0]   cur_l;
  logic [IW-1:0]   cur_r;
  logic [SPW-1:0]  sp;
  logic [NW-1:0]   stk_k [SD];
  logic [IW-1:0]   stk_l [SD];
  logic [IW-1:0]   stk_r [SD];
  logic            stk_ph [SD];
  logic [NW-1:0]   clr_addr;

  logic [IW-1:0]   mid;
  logic [SPW-1:0]  top;
  logic [SIW-1:0]  tix;
  logic [IW-1:0]   t_mid;
  logic [NW-1:0]   kl;
  logic [NW-1:0]   kr;
  logic            disjoint;
  logic            covered;
  logic            accept;
  logic [XW-1:0]   hi_x;
  logic [XW-1:0]   cnt_x;
  logic [XW-1:0]   qr_x;
  logic            empty;
  logic [XW-1:0]   cfg_x;
  logic [XW-1:0]   cfg_clamped;

  assign mid      = cur_l + ((cur_r - cur_l) >> 1);
  assign top      = sp - 1'b1;
  assign tix      = top[SIW-1:0];
  assign t_mid    = stk_l[tix] + ((stk_r[tix] - stk_l[tix]) >> 1);
  assign kl       = {cur_k[NW-2:0], 1'b0};
  assign kr       = {cur_k[NW-2:0], 1'b1};
  assign disjoint = (cur_l >= qr) || (cur_r <= ql);
  assign covered  = (ql <= cur_l) && (cur_r <= qr);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign hi_x     = XW'(in_high);
  assign cnt_x    = XW'(count);
  assign qr_x     = (hi_x > cnt_x) ? cnt_x : hi_x;
  assign empty    = XW'(in_low) >= qr_x;
  assign cfg_x    = XW'(cfg_wr_data);

  always_comb begin
    if (cfg_x == '0) begin
      cfg_clamped = XW'(1);
    end else if (cfg_x > XW'(ELEMENTS)) begin
      cfg_clamped = XW'(ELEMENTS);
    end else begin
      cfg_clamped = cfg_x;
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.wsel = WS_CLEAR;
    addr     = cur_k;
    unique case (state)
      S_CLEAR: begin
        cmd.wr = 1'b1;
        addr   = clr_addr;
      end
      S_IDLE: begin
        cmd.op_load  = accept;
        cmd.acc_init = accept;
      end
      S_VISIT: cmd.rd = !disjoint;
      S_COV: begin
        if (op == OP_MIN) begin
          cmd.acc_fold = 1'b1;
        end else begin
          cmd.wr   = 1'b1;
          cmd.wsel = WS_APPLY_OP;
        end
      end
      S_PUSH_K: begin
        cmd.tag_load = 1'b1;
        cmd.wr       = 1'b1;
        cmd.wsel     = WS_STRIP;
      end
      S_CH_RD_L: begin
        cmd.rd = 1'b1;
        addr   = kl;
      end
      S_CH_WR_L: begin
        cmd.wr   = 1'b1;
        cmd.wsel = WS_APPLY_TAG;
        addr     = kl;
      end
      S_CH_RD_R: begin
        cmd.rd = 1'b1;
        addr   = kr;
      end
      S_CH_WR_R: begin
        cmd.wr   = 1'b1;
        cmd.wsel = WS_APPLY_TAG;
        addr     = kr;
      end
      S_CMB_L: begin
        cmd.rd = 1'b1;
        addr   = kl;
      end
      S_CMB_R: begin
        cmd.rd        = 1'b1;
        cmd.left_load = 1'b1;
        addr          = kr;
      end
      S_CMB_W: begin
        cmd.wr   = 1'b1;
        cmd.wsel = WS_COMBINE;
      end
      S_DONE: cmd.out_load = !status.out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      count    <= IW'(ELEMENTS);
      clr_addr <= '0;
      sp       <= '0;
      op       <= OP_NONE;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == NW'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op    <= opcode_t'(in_opcode);
            ql    <= IW'(in_low);
            qr    <= qr_x[IW-1:0];
            cur_k <= NW'(1);
            cur_l <= '0;
            cur_r <= count;
            sp    <= '0;
            if (in_opcode == OP_NONE) begin
              state <= S_IDLE;
            end else if (empty) begin
              state <= (in_opcode == OP_MIN) ? S_DONE : S_IDLE;
            end else begin
              state <= S_VISIT;
            end
          end
        end
        S_VISIT: begin
          if (disjoint) begin
            state <= S_RETURN;
          end else if (covered) begin
            state <= S_COV;
          end else begin
            state <= S_PUSH_K;
          end
        end
        S_COV: state <= S_RETURN;
        S_PUSH_K: state <= status.tag_active ? S_CH_RD_L : S_DESCEND;
        S_CH_RD_L: state <= S_CH_WR_L;
        S_CH_WR_L: state <= S_CH_RD_R;
        S_CH_RD_R: state <= S_CH_WR_R;
        S_CH_WR_R: state <= S_DESCEND;
        S_DESCEND: begin
          stk_k[sp[SIW-1:0]]  <= cur_k;
          stk_l[sp[SIW-1:0]]  <= cur_l;
          stk_r[sp[SIW-1:0]]  <= cur_r;
          stk_ph[sp[SIW-1:0]] <= 1'b0;
          sp    <= sp + 1'b1;
          cur_k <= kl;
          cur_r <= mid;
          state <= S_VISIT;
        end
        S_RETURN: begin
          if (sp == '0) begin
            state <= (op == OP_MIN) ? S_DONE : S_IDLE;
          end else if (!stk_ph[tix]) begin
            stk_ph[tix] <= 1'b1;
            cur_k <= {stk_k[tix][NW-2:0], 1'b1};
            cur_l <= t_mid;
            cur_r <= stk_r[tix];
            state <= S_VISIT;
          end else begin
            sp    <= top;
            cur_k <= stk_k[tix];
            cur_l <= stk_l[tix];
            cur_r <= stk_r[tix];
            state <= (op == OP_MIN) ? S_RETURN : S_CMB_L;
          end
        end
        S_CMB_L: state <= S_CMB_R;
        S_CMB_R: state <= S_CMB_W;
        S_CMB_W: state <= S_RETURN;
        S_DONE: begin
          if (!status.out_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr_en) begin
        count    <= cfg_clamped[IW-1:0];
        clr_addr <= '0;
        state    <= S_CLEAR;
      end
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(SD))
    else $error("walk stack overflow");

  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    accept |-> sp == '0)
    else $error("beat accepted with a walk still open");

  a_one_port: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> !cmd.wr)
    else $error("node memory read and written in one cycle");

endmodule

[hw/rtl/range_set_add_min_tree.sv]
// Range assign, saturating range add and range minimum over element_count
// signed 64-bit elements, held as a lazy segment tree in a single-port node
// memory of 4*ELEMENTS entries. An operation visits each node outside or fully
// inside its range; on each node that it splits it pushes any pending tag down
// to both children, descends, and after an update recombines the children. At
// most about four nodes per tree level are visited; the node memory port, used
// for a read or a write but not both at once, bounds the speed. After reset
// and after every write of element_count the tree is cleared by a pass over all
// 4*ELEMENTS nodes, during which no input beat is taken. An input beat may be
// taken while a query result still waits on the output.
module range_set_add_min_tree #(
  parameter int ELEMENTS = rsam_pkg::ELEMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rsam_pkg::CFG_W-1:0]  cfg_wr_data,
  rsam_in_if.sink                     in_ch,
  rsam_out_if.source                  out_ch
);
  import rsam_pkg::*;

  dp_cmd_t                        cmd;
  dp_status_t                     status;
  logic [$clog2(4*ELEMENTS)-1:0]  addr;

  rsam_ctrl #(.ELEMENTS(ELEMENTS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_opcode   (in_ch.opcode),
    .in_low      (in_ch.range_low),
    .in_high     (in_ch.range_high),
    .in_ready    (in_ch.ready),
    .cmd         (cmd),
    .addr        (addr),
    .status      (status)
  );

  rsam_dp #(.ELEMENTS(ELEMENTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .in_opcode (in_ch.opcode),
    .in_value  (in_ch.operand_value),
    .status    (status),
    .out_value (out_ch.min_value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

endmodule
